// ===== rtl/core/dsc_pkg.sv =====
// Shared types, codes and the class decision for the distribution shape classifier.
package dsc_pkg;

    // Starting direction codes.
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Shape class codes.
    typedef enum logic [1:0] {
        SHAPE_DECREASING = 2'd0,
        SHAPE_CONICAL    = 2'd1,
        SHAPE_BUMP       = 2'd2,
        SHAPE_OTHER      = 2'd3
    } shape_t;

    // Saturation limit of the peak and sample counters.
    localparam logic [1:0] COUNT_MAX   = 2'd3;
    // A distribution needs at least this many samples to be classified.
    localparam logic [1:0] MIN_SAMPLES = 2'd3;

    // One classification beat.
    typedef struct packed {
        shape_t     shape_class;
        logic [1:0] peak_count;
        dir_t       start_direction;
        logic       too_short;
    } result_t;

    // Maps peak count and starting direction to a shape class.
    function automatic shape_t classify(input logic [1:0] peaks, input dir_t dir);
        shape_t cls;
        cls = SHAPE_OTHER;
        case (peaks)
            2'd0:    if (dir == DIR_DOWN) cls = SHAPE_DECREASING;
            2'd1:    if (dir == DIR_UP)   cls = SHAPE_CONICAL;
            2'd2:    if (dir == DIR_UP)   cls = SHAPE_BUMP;
            default: cls = SHAPE_OTHER;
        endcase
        return cls;
    endfunction

endpackage

// ===== rtl/core/dsc_in_stage.sv =====
// Input register stage holding one accepted sample beat.
module dsc_in_stage #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   drain,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    output logic                   held_valid,
    output logic [SAMPLE_BITS-1:0] held_sample,
    output logic                   held_last
);

    logic                   valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   last_reg;

    // Valid flag: set on a new beat, cleared when the beat moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (drain)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample;
            last_reg   <= last;
        end
    end

    assign held_valid  = valid_reg;
    assign held_sample = sample_reg;
    assign held_last   = last_reg;

endmodule

// ===== rtl/core/dsc_track.sv =====
// Running shape state: direction, rise flag, peak and sample counters.
module dsc_track #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    output dsc_pkg::result_t       result
);
    import dsc_pkg::*;

    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [1:0]             seen_reg;
    logic                   in_rise_reg;
    logic [1:0]             peaks_reg;
    dir_t                   dir_reg;

    logic [1:0] seen_next;
    logic       in_rise_next;
    logic [1:0] peaks_next;
    dir_t       dir_next;
    logic       rise;
    logic       fall;

    // Compare with the previous sample and update the flags.
    always_comb
    begin
        rise         = (seen_reg != 2'd0) && (sample > prev_reg);
        fall         = (seen_reg != 2'd0) && (sample < prev_reg);
        dir_next     = dir_reg;
        in_rise_next = in_rise_reg;
        peaks_next   = peaks_reg;
        if (rise)
        begin
            if (dir_reg == DIR_NONE)
                dir_next = DIR_UP;
            in_rise_next = 1'b1;
        end
        else if (fall)
        begin
            if (dir_reg == DIR_NONE)
                dir_next = DIR_DOWN;
            if (in_rise_reg)
            begin
                if (peaks_reg != COUNT_MAX)
                    peaks_next = peaks_reg + 2'd1;
                in_rise_next = 1'b0;
            end
        end
        seen_next = (seen_reg != COUNT_MAX) ? seen_reg + 2'd1 : seen_reg;
    end

    // Result of the distribution if this beat is its last.
    always_comb
    begin
        result.too_short       = (seen_next < MIN_SAMPLES);
        result.peak_count      = peaks_next;
        result.start_direction = dir_next;
        result.shape_class     = result.too_short ? SHAPE_OTHER
                                                  : classify(peaks_next, dir_next);
    end

    // State update; the last beat returns everything to the start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            seen_reg    <= 2'd0;
            in_rise_reg <= 1'b0;
            peaks_reg   <= 2'd0;
            dir_reg     <= DIR_NONE;
        end
        else if (step)
        begin
            if (last)
            begin
                prev_reg    <= '0;
                seen_reg    <= 2'd0;
                in_rise_reg <= 1'b0;
                peaks_reg   <= 2'd0;
                dir_reg     <= DIR_NONE;
            end
            else
            begin
                prev_reg    <= sample;
                seen_reg    <= seen_next;
                in_rise_reg <= in_rise_next;
                peaks_reg   <= peaks_next;
                dir_reg     <= dir_next;
            end
        end
    end

    // Peaks never go down within a distribution.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !last |=> peaks_reg >= $past(peaks_reg))
        else $error("peak count decreased within a distribution");

    // The starting direction, once known, holds until the end.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !last && dir_reg != DIR_NONE |=> dir_reg == $past(dir_reg))
        else $error("starting direction changed");

    // The last beat leaves a clean state.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> seen_reg == 2'd0 && peaks_reg == 2'd0 && !in_rise_reg)
        else $error("state not cleared after last beat");

endmodule

// ===== rtl/core/distribution_shape_classifier_unit.sv =====
// Top level of the distribution shape classifier.
// A last beat's result passes through the input register and then the result register.
// Throughput: one sample beat per cycle; the input register and result register
// decouple the channels. A waiting result holds a last beat in the input register,
// and that held beat stalls the input until the result is taken.
// Reset: rst_n asynchronous, active low; clears the running state and both valid flags.
module distribution_shape_classifier_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dsc_pkg::shape_t        shape_class,
    output logic [1:0]             peak_count,
    output dsc_pkg::dir_t          start_direction,
    output logic                   too_short
);
    import dsc_pkg::*;

    logic                   s1_valid;
    logic [SAMPLE_BITS-1:0] s1_sample;
    logic                   s1_last;
    logic                   s1_fire;
    logic                   out_free;
    logic                   in_fire;
    result_t                result;
    logic                   out_valid_reg;
    result_t                out_reg;

    // Stage handshake: a non-last beat always moves; a last one needs a free result slot.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid && (!s1_last || out_free);
    assign in_ready = !s1_valid || s1_fire;
    assign in_fire  = in_valid && in_ready;

    dsc_in_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_fire),
        .drain       (s1_fire),
        .sample      (sample),
        .last        (last),
        .held_valid  (s1_valid),
        .held_sample (s1_sample),
        .held_last   (s1_last)
    );

    dsc_track #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_fire),
        .sample (s1_sample),
        .last   (s1_last),
        .result (result)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload capture.
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last)
        begin
            out_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign shape_class     = out_reg.shape_class;
    assign peak_count      = out_reg.peak_count;
    assign start_direction = out_reg.start_direction;
    assign too_short       = out_reg.too_short;

    // A short distribution is always classed as other.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.too_short |-> out_reg.shape_class == SHAPE_OTHER)
        else $error("short distribution not classed as other");

    // The input side only stalls behind a held beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid && s1_last && out_valid_reg && !out_ready)
        else $error("input stalled without cause");

    // A conical result carries exactly one peak.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.shape_class == SHAPE_CONICAL |-> out_reg.peak_count == 2'd1)
        else $error("conical class with wrong peak count");

endmodule

// ===== tb/tb_distribution_shape_classifier_unit.sv =====
// Self-checking testbench for the distribution shape classifier top level.
`timescale 1ns / 100ps

module tb_distribution_shape_classifier_unit;

    import dsc_pkg::*;

    localparam int SAMPLE_W    = 16;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BEATS = 650;
    localparam int TAIL_BEATS   = 50;

    // Walk styles for the random distributions.
    localparam int STYLE_NOISE  = 0;
    localparam int STYLE_JITTER = 1;
    localparam int STYLE_HILLS  = 2;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                last = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    shape_t              shape_class;
    logic [1:0]          peak_count;
    dir_t                start_direction;
    logic                too_short;

    // Running copy of the classifier state.
    logic [SAMPLE_W-1:0] prev_sample = '0;
    logic [1:0]          seen_cnt = '0;
    logic                rising = 1'b0;
    logic [1:0]          peaks = '0;
    dir_t                first_dir = DIR_NONE;

    result_t             pending_shapes[$];
    logic [SAMPLE_W-1:0] directed_points[$];
    int                  mismatches = 0;
    int                  beats_sent = 0;
    int                  cycle_count = 0;
    int                  out_stall_left = 0;
    bit                  in_idle_on = 1'b1;
    bit                  out_idle_on = 1'b1;

    distribution_shape_classifier_unit #(
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample(sample),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .shape_class(shape_class),
        .peak_count(peak_count),
        .start_direction(start_direction),
        .too_short(too_short)
    );

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (out_stall_left != 0)
        begin
            out_stall_left = out_stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (out_idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall_left = $urandom_range(1, 7) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare every result beat with the oldest predicted shape.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_shapes.size() == 0)
            begin
                $display("%0t: expected no result beat, actual class %0d peaks %0d dir %0d",
                         $time, shape_class, peak_count, start_direction);
                $display("%0t: unexpected result beat, actual short %0d",
                         $time, too_short);
                mismatches++;
            end
            else
            begin
                result_t exp_shape;
                exp_shape = pending_shapes.pop_front();
                if (shape_class !== exp_shape.shape_class)
                begin
                    $display("%0t: shape_class expected %0d, actual %0d",
                             $time, exp_shape.shape_class, shape_class);
                    mismatches++;
                end
                if (peak_count !== exp_shape.peak_count)
                begin
                    $display("%0t: peak_count expected %0d, actual %0d",
                             $time, exp_shape.peak_count, peak_count);
                    mismatches++;
                end
                if (start_direction !== exp_shape.start_direction)
                begin
                    $display("%0t: start_direction expected %0d, actual %0d",
                             $time, exp_shape.start_direction, start_direction);
                    mismatches++;
                end
                if (too_short !== exp_shape.too_short)
                begin
                    $display("%0t: too_short expected %0d, actual %0d",
                             $time, exp_shape.too_short, too_short);
                    mismatches++;
                end
            end
        end
    end

    // Update the running shape state with one accepted sample and
    // queue the classification when the distribution ends.
    task automatic track_shape(input logic [SAMPLE_W-1:0] value, input logic is_last);
        result_t verdict;
        if (seen_cnt != 2'd0)
        begin
            if (value > prev_sample)
            begin
                if (first_dir == DIR_NONE)
                    first_dir = DIR_UP;
                rising = 1'b1;
            end
            else if (value < prev_sample)
            begin
                if (first_dir == DIR_NONE)
                    first_dir = DIR_DOWN;
                if (rising)
                begin
                    if (peaks != COUNT_MAX)
                        peaks = peaks + 2'd1;
                    rising = 1'b0;
                end
            end
        end
        prev_sample = value;
        if (seen_cnt != COUNT_MAX)
            seen_cnt = seen_cnt + 2'd1;

        if (is_last)
        begin
            verdict.too_short       = (seen_cnt < MIN_SAMPLES);
            verdict.peak_count      = peaks;
            verdict.start_direction = first_dir;
            if (verdict.too_short)
                verdict.shape_class = SHAPE_OTHER;
            else if (peaks == 2'd0 && first_dir == DIR_DOWN)
                verdict.shape_class = SHAPE_DECREASING;
            else if (peaks == 2'd1 && first_dir == DIR_UP)
                verdict.shape_class = SHAPE_CONICAL;
            else if (peaks == 2'd2 && first_dir == DIR_UP)
                verdict.shape_class = SHAPE_BUMP;
            else
                verdict.shape_class = SHAPE_OTHER;
            pending_shapes.insert(pending_shapes.size(), verdict);

            // The block starts over after each distribution.
            prev_sample = '0;
            seen_cnt    = '0;
            rising      = 1'b0;
            peaks       = '0;
            first_dir   = DIR_NONE;
        end
    endtask

    // Present one sample beat, wait for it to be taken, then maybe idle.
    // Called and returning on a rising edge.
    task automatic send_beat(input logic [SAMPLE_W-1:0] value, input logic is_last);
        in_valid <= 1'b1;
        sample   <= value;
        last     <= is_last;
        do
            @(posedge clk);
        while (!in_ready);
        track_shape(value, is_last);
        beats_sent++;
        if (in_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Send the directed points as one distribution, then clear the list.
    task automatic send_points();
        int idx;
        for (idx = 0; idx < directed_points.size(); idx++)
            send_beat(directed_points[idx], idx == directed_points.size() - 1);
        directed_points.delete();
    endtask

    // Send one random distribution of the given length and style.
    task automatic send_distribution(input int len, input int style);
        int  idx;
        int  level;
        int  step;
        bit  going_up;
        level    = $urandom_range(0, SAMPLE_MAX);
        going_up = ($urandom_range(0, 1) == 1);
        for (idx = 0; idx < len; idx++)
        begin
            case (style)
                STYLE_NOISE:  level = $urandom_range(0, SAMPLE_MAX);
                STYLE_JITTER: level = level + int'($urandom_range(0, 4)) - 2;
                default:
                begin
                    // Runs up and down with occasional flat steps.
                    step = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(1, 400));
                    level = going_up ? level + step : level - step;
                    if ($urandom_range(0, 2) == 0)
                        going_up = !going_up;
                end
            endcase
            if (level < 0)
                level = 0;
            if (level > SAMPLE_MAX)
                level = SAMPLE_MAX;
            send_beat(level[SAMPLE_W-1:0], idx == len - 1);
        end
    endtask

    // Pick a length, mostly well-formed, sometimes too short or long.
    task automatic send_random_distribution();
        int len;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2)
            len = $urandom_range(1, 2);
        else if (pick == 19)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(3, 12);
        pick = $urandom_range(0, 9);
        if (pick < 2)
            send_distribution(len, STYLE_NOISE);
        else if (pick < 4)
            send_distribution(len, STYLE_JITTER);
        else
            send_distribution(len, STYLE_HILLS);
    endtask

    // One- and two-sample distributions at the sample extremes.
    task automatic test_short_distributions();
        directed_points = '{16'hFFFF};
        send_points();
        directed_points = '{16'h0000, 16'hFFFF};
        send_points();
    endtask

    // Flat and strictly falling distributions.
    task automatic test_monotonic_shapes();
        directed_points = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_points();
        directed_points = '{16'hFFFF, 16'h8000, 16'h0000};
        send_points();
    endtask

    // Single peak, a bump with a flat stretch, and peak count saturation.
    task automatic test_peak_shapes();
        directed_points = '{16'h0000, 16'hFFFF, 16'h0000};
        send_points();
        directed_points = '{16'h0001, 16'h0005, 16'h0005, 16'h0002, 16'h0007, 16'h0003};
        send_points();
        directed_points = '{16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0000,
                            16'h0001, 16'h0000, 16'h0001, 16'h0000};
        send_points();
    endtask

    // Random distributions, with some of them sent back to back.
    task automatic test_random_distributions();
        while (beats_sent < RANDOM_BEATS)
        begin
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 7) != 0);
            send_random_distribution();
        end
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_unpaced_tail();
        int tail_start;
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        tail_start  = beats_sent;
        while (beats_sent < tail_start + TAIL_BEATS)
            send_random_distribution();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_distributions();
        test_monotonic_shapes();
        test_peak_shapes();
        test_random_distributions();
        test_unpaced_tail();

        // Drain outstanding results, then allow for the output latency.
        in_valid <= 1'b0;
        while (pending_shapes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
